// ===== hdl/bfca_pkg.sv =====
// Shared types and codes for the best-fit coalescing allocator.
// No dependencies; imported by the remainder unit, the table module, the top level and the bench.
`timescale 1ns / 1ps

package bfca_pkg;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FREE_FULL  = 2'd1;
    localparam logic [1:0] ST_USED_FULL  = 2'd2;
    localparam logic [1:0] ST_UNKNOWN    = 2'd3;

    localparam int unsigned ALIGN_BITS  = 17;
    localparam int unsigned SIZE_BITS   = 32;
    localparam int unsigned OUT_BITS    = 72;

    // Write/clear strobes for one block table.
    typedef struct packed {
        logic wr;
        logic set_v;
        logic clr;
    } t_tbl_cmd;

endpackage

// ===== hdl/best_fit_coalescing_allocator.sv =====
// Best-fit coalescing allocator top level: sequencer, heap top, output register.
// Allocate: remainder unit, one free-table pass, an address step, then one used-table pass,
// one read per cycle. Free: used-table pass, then free-table pass; an unknown or zero-length
// block skips the free-table pass.
// One request at a time; ready again after the result is registered; a held result stalls.
// Synchronous active-low reset clears valid flags, heap top, alignment (64); no sweep.
// Depends on bfca_pkg, bfca_round and bfca_tbl.
`timescale 1ns / 1ps

module best_fit_coalescing_allocator
    import bfca_pkg::*;
#(
    parameter int FREE_ENTRIES = 64,
    parameter int USED_ENTRIES = 256,
    parameter int ADDR_BITS    = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [ALIGN_BITS-1:0] i_cfg_data,     // alignment
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,   // request_size, free_address
    input  logic                  s_axis_tuser,   // command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_BITS-1:0]   m_axis_tdata    // block_address, status, heap_top, pad
);

    localparam int AW  = ADDR_BITS;
    localparam int FIW = $clog2(FREE_ENTRIES);
    localparam int UIW = $clog2(USED_ENTRIES);
    localparam int CW  = ((FIW > UIW) ? FIW : UIW) + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_FSCAN  = 3'd2;
    localparam logic [2:0] S_ADDR   = 3'd3;
    localparam logic [2:0] S_USCAN  = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;

    logic [2:0]            r_state;
    logic                  r_cmd;
    logic [ALIGN_BITS-1:0] r_align;
    logic [31:0]           r_raw;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         r_rsz;
    logic [AW-1:0]         r_top;

    logic [CW-1:0]         r_idx;
    logic                  r_pv;
    logic [CW-2:0]         r_pidx;

    logic                  r_best_f;
    logic [FIW-1:0]        r_best_idx;
    logic [AW-1:0]         r_best_start;
    logic [AW-1:0]         r_best_len;
    logic                  r_hi_f;
    logic [FIW-1:0]        r_hi_idx;
    logic [AW-1:0]         r_hi_start;
    logic [AW-1:0]         r_hi_len;
    logic                  r_up_f;
    logic [FIW-1:0]        r_up_idx;
    logic [AW-1:0]         r_up_len;
    logic                  r_lo_f;
    logic [FIW-1:0]        r_lo_idx;
    logic [AW-1:0]         r_lo_start;
    logic [AW-1:0]         r_lo_len;
    logic                  r_emp_f;
    logic [FIW-1:0]        r_emp_idx;
    logic                  r_m_f;
    logic [UIW-1:0]        r_m_idx;
    logic [AW-1:0]         r_m_len;
    logic                  r_slot_f;
    logic [UIW-1:0]        r_slot_idx;

    logic                  r_ovalid;
    logic [OUT_BITS-1:0]   r_odata;

    logic                  w_accept;
    logic                  w_commit;
    logic                  w_scan_end;
    logic                  w_div_done;
    logic [AW-1:0]         w_rounded;

    t_tbl_cmd              f_cmd;
    logic [FIW-1:0]        f_wr_idx;
    logic [AW-1:0]         f_wr_start;
    logic [AW-1:0]         f_wr_len;
    logic [FIW-1:0]        f_clr_idx;
    logic [AW-1:0]         f_rd_start;
    logic [AW-1:0]         f_rd_len;
    logic                  f_rd_valid;

    t_tbl_cmd              u_cmd;
    logic [UIW-1:0]        u_wr_idx;
    logic [AW-1:0]         u_rd_start;
    logic [AW-1:0]         u_rd_len;
    logic                  u_rd_valid;

    logic [AW-1:0]         w_fend;
    logic [AW-1:0]         w_free_end;
    logic [AW-1:0]         w_hi_end;
    logic [AW-1:0]         n_addr;
    logic [AW-1:0]         n_top;
    logic [1:0]            n_status;
    logic [31:0]           n_out_addr;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign w_accept   = s_axis_tvalid && (r_state == S_IDLE);
    assign w_commit   = (r_state == S_COMMIT) && (!r_ovalid || m_axis_tready);
    assign w_scan_end = !r_pv && (r_idx == ((r_state == S_FSCAN) ?
                        CW'(FREE_ENTRIES) : CW'(USED_ENTRIES)));

    assign w_fend     = f_rd_start + f_rd_len;
    assign w_free_end = r_addr + r_m_len;
    assign w_hi_end   = r_hi_start + r_hi_len;

    bfca_round #(
        .ADDR_BITS (AW)
    ) u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept && (s_axis_tuser == CMD_ALLOC)),
        .i_size    (s_axis_tdata[31:0]),
        .i_align   (r_align),
        .o_done    (w_div_done),
        .o_rounded (w_rounded)
    );

    bfca_tbl #(
        .DEPTH     (FREE_ENTRIES),
        .ADDR_BITS (AW)
    ) u_free_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (f_cmd),
        .i_rd_idx   (r_idx[FIW-1:0]),
        .i_wr_idx   (f_wr_idx),
        .i_wr_start (f_wr_start),
        .i_wr_len   (f_wr_len),
        .i_clr_idx  (f_clr_idx),
        .o_rd_start (f_rd_start),
        .o_rd_len   (f_rd_len),
        .o_rd_valid (f_rd_valid)
    );

    bfca_tbl #(
        .DEPTH     (USED_ENTRIES),
        .ADDR_BITS (AW)
    ) u_used_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (u_cmd),
        .i_rd_idx   (r_idx[UIW-1:0]),
        .i_wr_idx   (u_wr_idx),
        .i_wr_start (r_addr),
        .i_wr_len   (r_rsz),
        .i_clr_idx  (r_m_idx),
        .o_rd_start (u_rd_start),
        .o_rd_len   (u_rd_len),
        .o_rd_valid (u_rd_valid)
    );

    always_comb begin
        if (r_best_f) begin
            n_addr = r_best_start;
        end else if (r_hi_f && (w_hi_end >= r_top)) begin
            n_addr = r_hi_start;
        end else begin
            n_addr = r_top;
        end
    end

    always_comb begin
        f_cmd      = '0;
        f_wr_idx   = r_best_idx;
        f_wr_start = r_best_start + r_rsz;
        f_wr_len   = r_best_len - r_rsz;
        f_clr_idx  = r_best_idx;
        u_cmd      = '0;
        u_wr_idx   = r_m_f ? r_m_idx : r_slot_idx;
        n_top      = r_top;
        n_status   = ST_OK;
        n_out_addr = r_raw;
        if (r_cmd == CMD_ALLOC) begin
            n_out_addr = 32'(r_addr);
            if (!r_m_f && !r_slot_f) begin
                n_status   = ST_USED_FULL;
                n_out_addr = '0;
            end else begin
                u_cmd.wr    = 1'b1;
                u_cmd.set_v = 1'b1;
                if (r_rsz != '0) begin
                    if (r_best_f) begin
                        if (r_best_len > r_rsz) begin
                            f_cmd.wr = 1'b1;
                        end else begin
                            f_cmd.clr = 1'b1;
                        end
                    end else begin
                        if (r_hi_f && (r_addr == r_hi_start)) begin
                            f_cmd.clr = 1'b1;
                            f_clr_idx = r_hi_idx;
                        end
                        n_top = r_addr + r_rsz;
                    end
                end
            end
        end else begin
            f_cmd.set_v = 1'b1;
            if (!r_m_f) begin
                n_status = ST_UNKNOWN;
            end else if (r_m_len == '0) begin
                u_cmd.clr = 1'b1;
            end else if (r_lo_f && r_up_f) begin
                f_cmd.wr   = 1'b1;
                f_wr_idx   = r_lo_idx;
                f_wr_start = r_lo_start;
                f_wr_len   = r_lo_len + r_m_len + r_up_len;
                f_cmd.clr  = 1'b1;
                f_clr_idx  = r_up_idx;
                u_cmd.clr  = 1'b1;
            end else if (r_lo_f) begin
                f_cmd.wr   = 1'b1;
                f_wr_idx   = r_lo_idx;
                f_wr_start = r_lo_start;
                f_wr_len   = r_lo_len + r_m_len;
                u_cmd.clr  = 1'b1;
            end else if (r_up_f) begin
                f_cmd.wr   = 1'b1;
                f_wr_idx   = r_up_idx;
                f_wr_start = r_addr;
                f_wr_len   = r_up_len + r_m_len;
                u_cmd.clr  = 1'b1;
            end else if (r_emp_f) begin
                f_cmd.wr   = 1'b1;
                f_wr_idx   = r_emp_idx;
                f_wr_start = r_addr;
                f_wr_len   = r_m_len;
                u_cmd.clr  = 1'b1;
            end else begin
                n_status = ST_FREE_FULL;
            end
        end
        if (!w_commit) begin
            f_cmd = '0;
            u_cmd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_align  <= ALIGN_BITS'(64);
            r_top    <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_pv     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_align <= i_cfg_data;
            end
            if (w_commit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            if (r_state == S_FSCAN || r_state == S_USCAN) begin
                r_pidx <= r_idx[CW-2:0];
                if (!w_scan_end && !(r_pv && r_idx == ((r_state == S_FSCAN) ?
                        CW'(FREE_ENTRIES) : CW'(USED_ENTRIES)))) begin
                    r_idx <= r_idx + CW'(1);
                    r_pv  <= 1'b1;
                end else begin
                    r_pv  <= 1'b0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= s_axis_tuser;
                        r_raw    <= s_axis_tdata[63:32];
                        r_addr   <= AW'(s_axis_tdata[63:32]);
                        r_best_f <= 1'b0;
                        r_hi_f   <= 1'b0;
                        r_up_f   <= 1'b0;
                        r_lo_f   <= 1'b0;
                        r_emp_f  <= 1'b0;
                        r_m_f    <= 1'b0;
                        r_slot_f <= 1'b0;
                        r_idx    <= '0;
                        r_pv     <= 1'b0;
                        r_state  <= (s_axis_tuser == CMD_ALLOC) ? S_DIV : S_USCAN;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_rsz   <= w_rounded;
                        r_state <= S_FSCAN;
                    end
                end
                S_FSCAN: begin
                    if (r_pv) begin
                        if (r_cmd == CMD_ALLOC) begin
                            if (f_rd_valid) begin
                                if (f_rd_len >= r_rsz && (!r_best_f ||
                                        f_rd_len < r_best_len ||
                                        (f_rd_len == r_best_len &&
                                         f_rd_start < r_best_start))) begin
                                    r_best_f     <= 1'b1;
                                    r_best_idx   <= r_pidx[FIW-1:0];
                                    r_best_start <= f_rd_start;
                                    r_best_len   <= f_rd_len;
                                end
                                if (!r_hi_f || f_rd_start > r_hi_start) begin
                                    r_hi_f     <= 1'b1;
                                    r_hi_idx   <= r_pidx[FIW-1:0];
                                    r_hi_start <= f_rd_start;
                                    r_hi_len   <= f_rd_len;
                                end
                            end
                        end else begin
                            if (!f_rd_valid) begin
                                if (!r_emp_f) begin
                                    r_emp_f   <= 1'b1;
                                    r_emp_idx <= r_pidx[FIW-1:0];
                                end
                            end else if (!r_up_f && f_rd_start == w_free_end) begin
                                r_up_f   <= 1'b1;
                                r_up_idx <= r_pidx[FIW-1:0];
                                r_up_len <= f_rd_len;
                            end else if (!r_lo_f && w_fend == r_addr) begin
                                r_lo_f     <= 1'b1;
                                r_lo_idx   <= r_pidx[FIW-1:0];
                                r_lo_start <= f_rd_start;
                                r_lo_len   <= f_rd_len;
                            end
                        end
                    end
                    if (w_scan_end) begin
                        r_idx   <= '0;
                        r_state <= (r_cmd == CMD_ALLOC) ? S_ADDR : S_COMMIT;
                    end
                end
                S_ADDR: begin
                    r_addr  <= n_addr;
                    r_idx   <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_USCAN;
                end
                S_USCAN: begin
                    if (r_pv) begin
                        if (!u_rd_valid) begin
                            if (!r_slot_f) begin
                                r_slot_f   <= 1'b1;
                                r_slot_idx <= r_pidx[UIW-1:0];
                            end
                        end else if (!r_m_f && u_rd_start == r_addr) begin
                            r_m_f   <= 1'b1;
                            r_m_idx <= r_pidx[UIW-1:0];
                            r_m_len <= u_rd_len;
                        end
                    end
                    if (w_scan_end) begin
                        r_idx <= '0;
                        if (r_cmd == CMD_FREE && r_m_f && r_m_len != '0) begin
                            r_state <= S_FSCAN;
                        end else begin
                            r_state <= S_COMMIT;
                        end
                    end
                end
                S_COMMIT: begin
                    if (w_commit) begin
                        r_top    <= n_top;
                        r_odata  <= {6'b0, 32'(n_top), n_status, n_out_addr};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/bfca_round.sv =====
// Iterative remainder unit: rounds a request size up to the alignment.
// One restoring compare/subtract step per cycle; uses bfca_pkg.
`timescale 1ns / 1ps

module bfca_round
    import bfca_pkg::*;
#(
    parameter int ADDR_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SIZE_BITS-1:0]  i_size,
    input  logic [ALIGN_BITS-1:0] i_align,
    output logic                  o_done,
    output logic [ADDR_BITS-1:0]  o_rounded
);

    localparam int SW = (ADDR_BITS > SIZE_BITS + 1) ? ADDR_BITS : SIZE_BITS + 1;

    logic                  r_busy;
    logic                  r_done;
    logic [4:0]            r_cnt;
    logic [SIZE_BITS-1:0]  r_shift;
    logic [SIZE_BITS-1:0]  r_size;
    logic [ALIGN_BITS-1:0] r_rem;
    logic [ALIGN_BITS-1:0] r_div;
    logic [ALIGN_BITS:0]   w_trial;
    logic [ALIGN_BITS-1:0] w_add;
    logic [SW-1:0]         w_sum;

    assign w_trial = {r_rem, r_shift[SIZE_BITS-1]};
    assign w_add   = (r_rem != '0) ? (r_div - r_rem) : '0;
    assign w_sum   = SW'(r_size) + SW'(w_add);
    assign o_rounded = w_sum[ADDR_BITS-1:0];
    assign o_done    = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_shift <= i_size;
                r_size  <= i_size;
                r_rem   <= '0;
                r_div   <= (i_align == '0) ? ALIGN_BITS'(1) : i_align;
            end else if (r_busy) begin
                if (w_trial >= {1'b0, r_div}) begin
                    r_rem <= ALIGN_BITS'(w_trial - {1'b0, r_div});
                end else begin
                    r_rem <= w_trial[ALIGN_BITS-1:0];
                end
                r_shift <= {r_shift[SIZE_BITS-2:0], 1'b0};
                r_cnt   <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/bfca_tbl.sv =====
// Block table: start/length memory with one registered read port,
// one write port and per-entry valid flags; uses bfca_pkg.
`timescale 1ns / 1ps

module bfca_tbl
    import bfca_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_tbl_cmd                   i_cmd,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_idx,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_idx,
    input  logic [ADDR_BITS-1:0]       i_wr_start,
    input  logic [ADDR_BITS-1:0]       i_wr_len,
    input  logic [$clog2(DEPTH)-1:0]   i_clr_idx,
    output logic [ADDR_BITS-1:0]       o_rd_start,
    output logic [ADDR_BITS-1:0]       o_rd_len,
    output logic                       o_rd_valid
);

    logic [2*ADDR_BITS-1:0] r_mem [DEPTH];
    logic [2*ADDR_BITS-1:0] r_rd_data;
    logic [DEPTH-1:0]       r_valid;
    logic                   r_rd_valid;

    assign o_rd_start = r_rd_data[2*ADDR_BITS-1:ADDR_BITS];
    assign o_rd_len   = r_rd_data[ADDR_BITS-1:0];
    assign o_rd_valid = r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_wr_idx] <= {i_wr_start, i_wr_len};
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_rd_idx];
            if (i_cmd.clr) begin
                r_valid[i_clr_idx] <= 1'b0;
            end
            if (i_cmd.wr && i_cmd.set_v) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for the best-fit coalescing allocator: a scoreboard class
// predicts each allocate/free response and checks the output stream in order.
// Depends on bfca_pkg and best_fit_coalescing_allocator.
`timescale 1ns / 1ps

class alloc_scoreboard;
    localparam int NFREE = 64;
    localparam int NUSED = 256;

    bit [16:0] align;
    bit [31:0] fr_start [NFREE];
    bit [31:0] fr_len   [NFREE];
    bit        fr_vld   [NFREE];
    bit [31:0] us_start [NUSED];
    bit [31:0] us_len   [NUSED];
    bit        us_vld   [NUSED];
    bit [31:0] heap_top;
    bit [65:0] pending [$];
    int        errors;
    bit [31:0] live_addr [$];

    function new();
        align = 17'd64;
        heap_top = 0;
        errors = 0;
        foreach (fr_vld[i]) fr_vld[i] = 0;
        foreach (us_vld[i]) us_vld[i] = 0;
    endfunction

    function int lookup_used(bit [31:0] addr);
        foreach (us_vld[i])
            if (us_vld[i] && us_start[i] == addr) return i;
        return -1;
    endfunction

    function void push(bit [31:0] addr, bit [1:0] st);
        pending.push_back({addr, st, heap_top});
    endfunction

    function void predict_alloc(bit [31:0] size);
        bit [63:0] a, r;
        bit [31:0] rr, addr;
        int slot, best, hi, m;
        a = (align == 0) ? 64'd1 : 64'(align);
        r = ((size / a) + ((size % a) != 0 ? 1 : 0)) * a;
        rr = r[31:0];
        slot = -1; best = -1; hi = -1;
        for (int i = 0; i < NUSED && slot < 0; i++)
            if (!us_vld[i]) slot = i;
        for (int i = 0; i < NFREE; i++) begin
            if (!fr_vld[i]) continue;
            if (fr_len[i] >= rr && (best < 0 || fr_len[i] < fr_len[best] ||
                (fr_len[i] == fr_len[best] && fr_start[i] < fr_start[best])))
                best = i;
            if (hi < 0 || fr_start[i] > fr_start[hi]) hi = i;
        end
        if (best >= 0) addr = fr_start[best];
        else if (hi >= 0 && 32'(fr_start[hi] + fr_len[hi]) >= heap_top) addr = fr_start[hi];
        else addr = heap_top;
        m = lookup_used(addr);
        if (m >= 0) slot = m;
        if (slot < 0) begin
            push(32'd0, bfca_pkg::ST_USED_FULL);
            return;
        end
        if (rr != 0) begin
            if (best >= 0) begin
                if (fr_len[best] > rr) begin
                    fr_start[best] += rr;
                    fr_len[best] -= rr;
                end else begin
                    fr_vld[best] = 0;
                end
            end else begin
                if (hi >= 0 && addr == fr_start[hi]) fr_vld[hi] = 0;
                heap_top = addr + rr;
            end
        end
        us_vld[slot] = 1;
        us_start[slot] = addr;
        us_len[slot] = rr;
        live_addr.push_back(addr);
        push(addr, bfca_pkg::ST_OK);
    endfunction

    function void predict_free(bit [31:0] addr);
        bit [31:0] len, fin;
        int u, lo, up, empty;
        u = lookup_used(addr);
        lo = -1; up = -1; empty = -1;
        if (u < 0) begin
            push(addr, bfca_pkg::ST_UNKNOWN);
            return;
        end
        len = us_len[u];
        if (len == 0) begin
            us_vld[u] = 0;
            push(addr, bfca_pkg::ST_OK);
            return;
        end
        fin = addr + len;
        for (int i = 0; i < NFREE; i++) begin
            if (!fr_vld[i]) begin
                if (empty < 0) empty = i;
                continue;
            end
            if (up < 0 && fr_start[i] == fin) up = i;
            else if (lo < 0 && 32'(fr_start[i] + fr_len[i]) == addr) lo = i;
        end
        if (lo >= 0 && up >= 0) begin
            fr_len[lo] = fr_len[lo] + len + fr_len[up];
            fr_vld[up] = 0;
        end else if (lo >= 0) begin
            fr_len[lo] += len;
        end else if (up >= 0) begin
            fr_start[up] = addr;
            fr_len[up] += len;
        end else if (empty >= 0) begin
            fr_vld[empty] = 1;
            fr_start[empty] = addr;
            fr_len[empty] = len;
        end else begin
            push(addr, bfca_pkg::ST_FREE_FULL);
            return;
        end
        us_vld[u] = 0;
        push(addr, bfca_pkg::ST_OK);
    endfunction

    function void note_request(bit cmd, bit [31:0] size, bit [31:0] addr);
        if (cmd == bfca_pkg::CMD_ALLOC) predict_alloc(size);
        else predict_free(addr);
    endfunction

    function void check_response(bit [71:0] data);
        bit [65:0] exp_word;
        if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, data);
            errors++;
            return;
        end
        exp_word = pending.pop_front();
        if (data[31:0] != exp_word[65:34]) begin
            $display("%0t: block_address expected %h actual %h", $time,
                     exp_word[65:34], data[31:0]);
            errors++;
        end
        if (data[33:32] != exp_word[33:32]) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_word[33:32], data[33:32]);
            errors++;
        end
        if (data[65:34] != exp_word[31:0]) begin
            $display("%0t: heap_top expected %h actual %h", $time,
                     exp_word[31:0], data[65:34]);
            errors++;
        end
    endfunction
endclass

module tb;
    import bfca_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [ALIGN_BITS-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_BITS-1:0]   m_axis_tdata;

    alloc_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    longint cycles;

    best_fit_coalescing_allocator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 64'd3000000) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver: random backpressure plus an optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) board.check_response(m_axis_tdata);
            m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(bit cmd, bit [31:0] size, bit [31:0] addr);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {addr, size};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(cmd, size, addr);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_alignment(bit [16:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.align = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic bit [31:0] pick_size();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'd0;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic bit [31:0] pick_free_addr();
        int k;
        if (board.live_addr.size() != 0 && $urandom_range(9) < 8) begin
            k = $urandom_range(board.live_addr.size() - 1);
            return board.live_addr[k];
        end
        return $urandom();
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 55) send_request(CMD_ALLOC, pick_size(), $urandom());
            else send_request(CMD_FREE, $urandom(), pick_free_addr());
        end
    endtask

    initial begin
        board = new();
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        recv_hold = 0;
        send_idle_pct = 30;
        recv_idle_pct = 67;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero size, extremes, merges, unknown free, wrap.
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_ALLOC, 64, 0);
        send_request(CMD_ALLOC, 100, 0);
        send_request(CMD_FREE, 0, 64);
        send_request(CMD_FREE, 0, 0);
        send_request(CMD_FREE, 0, 0);
        send_request(CMD_FREE, 0, 128);
        send_request(CMD_FREE, 0, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 32, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 200, 0);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF, 0);
        send_request(CMD_ALLOC, 32'h8000_0000, 0);
        write_alignment(17'd0);
        send_request(CMD_ALLOC, 3, 0);
        write_alignment(17'h10000);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_alignment(17'h1FFFF);
        send_request(CMD_ALLOC, 5, 0);
        write_alignment(17'd1);

        // Fill the used table and then the free table.
        for (int n = 0; n < 260; n++) send_request(CMD_ALLOC, 1, 0);
        for (int n = 0; n < 140; n += 2) send_request(CMD_FREE, 0, board.us_start[n]);

        // Long receiver hold-off with the sender still offering items.
        recv_hold = 1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                recv_hold = 0;
            end
            random_phase(20);
        join
        drain();

        write_alignment(17'd64);
        random_phase(450);
        send_idle_pct = 67;
        recv_idle_pct = 30;
        write_alignment(17'd8);
        random_phase(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_alignment(17'd4096);
        random_phase(300);
        write_alignment(17'($urandom_range(1, 17'h1FFFF)));
        random_phase(200);

        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/bfca_pkg.sv
hdl/bfca_round.sv
hdl/bfca_tbl.sv
hdl/best_fit_coalescing_allocator.sv
sim/tb.sv
